### rtl/kps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types and constants for the keypad scan event detector.
// ----------------------------------------------------------------------------
package kps_pkg;

    localparam int KEY_W      = 4;
    localparam int KEY_CODE_W = KEY_W + 1;
    localparam int STAMP_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 1;

    // decoded key code; the extra bit marks "no key"
    localparam logic [KEY_CODE_W-1:0] NO_KEY = 5'd16;

    // event kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_LONG    = 2'd3;

    // keypad layouts
    localparam logic [1:0] PAD_1X4 = 2'd0;
    localparam logic [1:0] PAD_4X3 = 2'd1;
    localparam logic [1:0] PAD_4X4 = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_KEYPAD_TYPE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TIME   = 1'd1;

    localparam logic [1:0]         KEYPAD_TYPE_RESET = PAD_4X4;
    localparam logic [STAMP_W-1:0] HOLD_TIME_RESET   = 32'd1000;

    typedef struct packed {
        logic [7:0]         row0_sense;
        logic [7:0]         row1_sense;
        logic [7:0]         row2_sense;
        logic [7:0]         row3_sense;
        logic [STAMP_W-1:0] now_ms;
    } scan_t;

    typedef struct packed {
        logic             event_valid;
        logic [1:0]       event_kind;
        logic [KEY_W-1:0] key_index;
    } event_t;

endpackage : kps_pkg
`default_nettype wire

### rtl/keypad_scan_event_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_scan_event_detector
// Turns keypad scans into press, release and long-press events.
//
// Usage:
//   s_* carries one scan per item (four row sense bytes and a ms stamp).
//   m_* returns exactly one event item per scan, in order; an item with
//   event_valid low means nothing happened on that scan.
//   cfg_* writes keypad_type (index 0) or hold_time_ms (index 1), as
//   cfg_addr selects; write only while no scans are in flight.
//   An accepted scan is held in the input register, then decoded and
//   classified into the output register.
//   Throughput is one scan per cycle while the output is not stalled;
//   the key history registers update as each scan moves on.
//   Reset: keypad_type = 4x4, hold 1000 ms, no previous key, not armed;
//   both pipeline stages empty.
//   If m_ready is held low the output register holds its item, the input
//   register fills, and then s_ready drops until the event is taken.
// ----------------------------------------------------------------------------
module keypad_scan_event_detector (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire kps_pkg::scan_t                     s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output kps_pkg::event_t                         m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [kps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [kps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import kps_pkg::*;

    logic [1:0]         keypad_type_reg, keypad_type_next;
    logic [STAMP_W-1:0] hold_time_reg, hold_time_next;

    scan_t  in_reg, in_next;
    logic   in_valid_reg, in_valid_next;
    event_t out_reg, out_next;
    logic   out_valid_reg, out_valid_next;

    logic                  advance;
    logic [KEY_CODE_W-1:0] key;
    event_t                evt;

    // configuration
    always_comb begin
        keypad_type_next = keypad_type_reg;
        hold_time_next   = hold_time_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_KEYPAD_TYPE: keypad_type_next = cfg_wdata[1:0];
                REG_HOLD_TIME:   hold_time_next   = cfg_wdata[STAMP_W-1:0];
                default:         keypad_type_next = keypad_type_reg;
            endcase
        end
    end

    // the scan in the input register moves on when the output slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_next       = in_reg;
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_next       = s_data;
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_next       = evt;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    kps_decode u_decode (
        .scan        (in_reg),
        .keypad_type (keypad_type_reg),
        .key         (key)
    );

    kps_tracker u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .key          (key),
        .now_ms       (in_reg.now_ms),
        .hold_time_ms (hold_time_reg),
        .evt          (evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keypad_type_reg <= KEYPAD_TYPE_RESET;
            hold_time_reg   <= HOLD_TIME_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            keypad_type_reg <= keypad_type_next;
            hold_time_reg   <= hold_time_next;
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule : keypad_scan_event_detector
`default_nettype wire

### rtl/kps_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kps_decode
// Priority decode of one scan into a key code; highest index wins.
// ----------------------------------------------------------------------------
module kps_decode (
    input  wire kps_pkg::scan_t                    scan,
    input  wire logic [1:0]                        keypad_type,
    output logic [kps_pkg::KEY_CODE_W-1:0]         key
);
    import kps_pkg::*;

    logic [7:0] rows [4];

    always_comb begin
        rows[0] = scan.row0_sense;
        rows[1] = scan.row1_sense;
        rows[2] = scan.row2_sense;
        rows[3] = scan.row3_sense;
    end

    // later hits overwrite earlier ones, so the highest index is kept
    always_comb begin
        key = NO_KEY;
        case (keypad_type)
            PAD_1X4: begin
                for (int c = 0; c < 4; c++) begin
                    if (!rows[0][c]) key = KEY_CODE_W'(c);
                end
            end
            PAD_4X3: begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        if (!rows[r][c+4]) key = KEY_CODE_W'(r * 3 + c);
                    end
                end
            end
            PAD_4X4: begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        if (!rows[r][c+4]) key = KEY_CODE_W'(r * 4 + c);
                    end
                end
            end
            default: begin
                key = NO_KEY;
            end
        endcase
    end

endmodule : kps_decode
`default_nettype wire

### rtl/kps_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kps_tracker
// Key history and long-press timer; classifies each decoded scan.
// ----------------------------------------------------------------------------
module kps_tracker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              step,
    input  wire logic [kps_pkg::KEY_CODE_W-1:0]    key,
    input  wire logic [kps_pkg::STAMP_W-1:0]       now_ms,
    input  wire logic [kps_pkg::STAMP_W-1:0]       hold_time_ms,
    output kps_pkg::event_t                        evt
);
    import kps_pkg::*;

    logic [KEY_CODE_W-1:0] prev_key_reg, prev_key_next;
    logic                  armed_reg, armed_next;
    logic [STAMP_W-1:0]    press_time_reg, press_time_next;

    logic               key_down, press, release_ev, long_ev;
    logic [STAMP_W-1:0] elapsed;

    assign key_down   = (key != NO_KEY);
    assign press      = key_down && (key != prev_key_reg);
    assign release_ev = !key_down && (prev_key_reg != NO_KEY) && armed_reg;
    assign elapsed    = now_ms - press_time_reg;
    // a press is masked out here, so it never also fires a long press
    assign long_ev    = key_down && !press && armed_reg && (elapsed > hold_time_ms);

    always_comb begin
        evt = '0;
        if (long_ev) begin
            evt.event_valid = 1'b1;
            evt.event_kind  = KIND_LONG;
            evt.key_index   = key[KEY_W-1:0];
        end else if (press) begin
            evt.event_valid = 1'b1;
            evt.event_kind  = KIND_PRESS;
            evt.key_index   = key[KEY_W-1:0];
        end else if (release_ev) begin
            evt.event_valid = 1'b1;
            evt.event_kind  = KIND_RELEASE;
            evt.key_index   = prev_key_reg[KEY_W-1:0];
        end
    end

    always_comb begin
        prev_key_next   = prev_key_reg;
        armed_next      = armed_reg;
        press_time_next = press_time_reg;
        if (step) begin
            prev_key_next = key;
            if (long_ev) begin
                armed_next      = 1'b0;
                press_time_next = now_ms;
            end else if (press) begin
                armed_next      = 1'b1;
                press_time_next = now_ms;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_key_reg   <= NO_KEY;
            armed_reg      <= 1'b0;
            press_time_reg <= '0;
        end else begin
            prev_key_reg   <= prev_key_next;
            armed_reg      <= armed_next;
            press_time_reg <= press_time_next;
        end
    end

endmodule : kps_tracker
`default_nettype wire

### tb/sv/kps_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_event_checker
// Watches the scan, event and register ports of the keypad scan event
// detector, predicts the event for every accepted scan and compares each
// returned event, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module kps_event_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire kps_pkg::scan_t                 s_data,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire kps_pkg::event_t                m_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [kps_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [kps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                  mismatch_count,
    output int                                  pending_events
);
    import kps_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // predictor's own copy of the registers and key history
    logic [1:0]            pad_layout;
    logic [STAMP_W-1:0]    hold_ms;
    logic [KEY_CODE_W-1:0] last_key;
    logic                  long_armed;
    logic [STAMP_W-1:0]    press_stamp;

    event_t expected_events[$];
    int     mismatch_tally = 0;
    int     events_seen    = 0;

    // highest index among the keys pulled low wins
    function automatic logic [KEY_CODE_W-1:0] decode_pressed_key(logic [1:0] layout,
                                                                 scan_t sc);
        logic [7:0]            rows [4];
        logic [KEY_CODE_W-1:0] found;
        int                    cols;
        rows[0] = sc.row0_sense;
        rows[1] = sc.row1_sense;
        rows[2] = sc.row2_sense;
        rows[3] = sc.row3_sense;
        found   = NO_KEY;
        cols    = 0;
        if (layout == PAD_1X4) begin
            for (int c = 0; c < 4; c++)
                if (!rows[0][c]) found = KEY_CODE_W'(c);
        end else begin
            if (layout == PAD_4X3)
                cols = 3;
            else if (layout == PAD_4X4)
                cols = 4;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < cols; c++)
                    if (!rows[r][c + 4]) found = KEY_CODE_W'(r * cols + c);
        end
        return found;
    endfunction

    function automatic event_t predict_event(scan_t sc);
        logic [KEY_CODE_W-1:0] key;
        logic [1:0]            kind;
        logic [KEY_W-1:0]      idx;
        logic [STAMP_W-1:0]    elapsed;
        event_t                ev;
        key  = decode_pressed_key(pad_layout, sc);
        kind = KIND_NONE;
        idx  = '0;
        if (key != NO_KEY && key != last_key) begin
            long_armed  = 1'b1;
            press_stamp = sc.now_ms;
            kind        = KIND_PRESS;
            idx         = key[KEY_W-1:0];
        end else if (key == NO_KEY && last_key != NO_KEY && long_armed) begin
            kind = KIND_RELEASE;
            idx  = last_key[KEY_W-1:0];
        end
        elapsed = sc.now_ms - press_stamp;   // wraps modulo 2^32
        if (key != NO_KEY && long_armed && elapsed > hold_ms) begin
            long_armed  = 1'b0;
            press_stamp = sc.now_ms;
            kind        = KIND_LONG;
            idx         = key[KEY_W-1:0];
        end
        last_key       = key;
        ev.event_valid = (kind != KIND_NONE);
        ev.event_kind  = kind;
        ev.key_index   = (kind != KIND_NONE) ? idx : '0;
        return ev;
    endfunction

    always @(posedge aclk) begin
        event_t got;
        event_t want;
        if (!aresetn) begin
            pad_layout  = KEYPAD_TYPE_RESET;
            hold_ms     = HOLD_TIME_RESET;
            last_key    = NO_KEY;
            long_armed  = 1'b0;
            press_stamp = '0;
            expected_events.delete();
        end else begin
            // retire before predicting: the returned item is always older
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_events.size() == 0) begin
                    mismatch_tally++;
                    if (mismatch_tally <= REPORT_LIMIT)
                        $display("ERROR: event %0d returned with no scan outstanding: %p",
                                 events_seen, got);
                end else begin
                    want = expected_events.pop_front();
                    if (got.event_valid !== want.event_valid ||
                        got.event_kind  !== want.event_kind  ||
                        got.key_index   !== want.key_index) begin
                        mismatch_tally++;
                        if (mismatch_tally <= REPORT_LIMIT)
                            $display({"ERROR: event %0d: expected valid=%0b kind=%0d ",
                                      "key=%0d, got valid=%0b kind=%0d key=%0d"},
                                     events_seen, want.event_valid, want.event_kind,
                                     want.key_index, got.event_valid, got.event_kind,
                                     got.key_index);
                    end
                end
                events_seen++;
            end
            if (s_valid && s_ready)
                expected_events.push_back(predict_event(s_data));
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_KEYPAD_TYPE: pad_layout = cfg_wdata[1:0];
                    REG_HOLD_TIME:   hold_ms    = cfg_wdata;
                    default: ;
                endcase
            end
        end
        mismatch_count <= mismatch_tally;
        pending_events <= expected_events.size();
    end

endmodule

### tb/sv/tb_keypad_scan_event_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_scan_event_detector
// Drives keypad scans into the detector: a directed pass over layouts, hold
// extremes, long presses, key changes and stamp wrap, then randomised
// press/hold/release sequences mixed with noise scans under several register
// settings, with random stalls on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_keypad_scan_event_detector;
    import kps_pkg::*;

    localparam logic [1:0] PAD_UNUSED      = 2'd3;
    localparam int         IDLE_LIMIT      = 2000;
    localparam int         PHASES          = 12;
    localparam int         PHASE_ITEMS     = 36;
    localparam int         HOLD_OFF_CYCLES = 60;
    localparam int         GAP_MAX         = 14;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    scan_t                 s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    event_t                m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int pending_events;

    int          tx_gap_max   = GAP_MAX;
    int          rx_gap_max   = GAP_MAX;
    logic        hold_off_req = 1'b0;
    logic [1:0]  stim_layout  = KEYPAD_TYPE_RESET;
    logic [31:0] stim_hold    = HOLD_TIME_RESET;
    logic [31:0] stim_clock   = '0;
    int          idle_cycles  = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    keypad_scan_event_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    kps_event_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_events (pending_events)
    );

    // event sink: random stall per item, one long hold-off on request
    initial begin
        int  gap;
        logic hold_off_done;
        hold_off_done = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = (rx_gap_max == 0) ? 0 : $urandom_range(rx_gap_max, 0);
            if (hold_off_req && !hold_off_done) begin
                gap           = HOLD_OFF_CYCLES;
                hold_off_done = 1'b1;
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no item moved for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_scan(input scan_t sc);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= sc;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic send_rows(input logic [7:0] r0, input logic [7:0] r1,
                             input logic [7:0] r2, input logic [7:0] r3,
                             input logic [31:0] now);
        scan_t sc;
        sc.row0_sense = r0;
        sc.row1_sense = r1;
        sc.row2_sense = r2;
        sc.row3_sense = r3;
        sc.now_ms     = now;
        send_scan(sc);
    endtask

    task automatic wait_until_events_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_events != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [31:0] layout_word, input logic [31:0] hold);
        wait_until_events_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_KEYPAD_TYPE;
        cfg_wdata <= layout_word;
        @(posedge aclk);
        cfg_addr  <= REG_HOLD_TIME;
        cfg_wdata <= hold;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        stim_layout = layout_word[1:0];
        stim_hold   = hold;
    endtask

    // one key held (or none); used column bits idle high, the rest random
    function automatic scan_t compose_scan(input int key);
        logic [7:0] rows [4];
        scan_t      sc;
        for (int r = 0; r < 4; r++) rows[r] = 8'($urandom());
        case (stim_layout)
            PAD_1X4: begin
                rows[0][3:0] = 4'hF;
                if (key < 4) rows[0][key] = 1'b0;
            end
            PAD_4X3: begin
                for (int r = 0; r < 4; r++) rows[r][6:4] = 3'b111;
                if (key < 12) rows[key / 3][key % 3 + 4] = 1'b0;
            end
            PAD_4X4: begin
                for (int r = 0; r < 4; r++) rows[r][7:4] = 4'hF;
                if (key < 16) rows[key / 4][key % 4 + 4] = 1'b0;
            end
            default: ;
        endcase
        sc.row0_sense = rows[0];
        sc.row1_sense = rows[1];
        sc.row2_sense = rows[2];
        sc.row3_sense = rows[3];
        sc.now_ms     = stim_clock;
        return sc;
    endfunction

    // small steps near the hold time so long presses fire; rare jumps
    task automatic advance_clock();
        if ($urandom_range(19, 0) == 0)
            stim_clock = $urandom();
        else
            stim_clock = stim_clock +
                         $urandom_range((stim_hold < 30) ? stim_hold + 4 : 30, 0);
    endtask

    task automatic run_scan_episodes(input int count);
        int    sent;
        int    held;
        int    key_count;
        int    key;
        scan_t noise;
        sent      = 0;
        key_count = (stim_layout == PAD_1X4) ? 4 : (stim_layout == PAD_4X3) ? 12 : 16;
        while (sent < count) begin
            if ($urandom_range(9, 0) < 2) begin
                noise = {$urandom(), $urandom()};
                send_scan(noise);
                sent++;
            end else begin
                key  = $urandom_range(key_count - 1, 0);
                held = $urandom_range(8, 1);
                for (int i = 0; i < held; i++) begin
                    advance_clock();
                    send_scan(compose_scan(key));
                    sent++;
                end
                // a third of the time the next key follows with no gap
                if ($urandom_range(2, 0) != 0) begin
                    advance_clock();
                    send_scan(compose_scan(NO_KEY));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [31:0] layout_word;
        logic [31:0] hold;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: 4x4, hold 1000
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd0);
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'h7F, 32'd10);
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'h7F, 32'd1010);
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'h7F, 32'd1011);
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'h7F, 32'd5000);
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd5001);
        send_rows(8'hEF, 8'hFF, 8'hFF, 8'hFF, 32'd6000);
        send_rows(8'hFF, 8'hDF, 8'hFF, 8'hFF, 32'd6001);
        send_rows(8'h00, 8'h00, 8'h00, 8'h00, 32'd6002);
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd6003);
        // press just before the stamp wraps, long press just after
        send_rows(8'hEF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFF0);
        send_rows(8'hEF, 8'hFF, 8'hFF, 8'hFF, 32'h0000_03E0);
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);

        // strip, zero hold: long press on any later stamp
        write_settings({30'd0, PAD_1X4}, 32'd0);
        send_rows(8'h00, 8'h00, 8'h00, 8'h00, 32'd100);
        send_rows(8'h00, 8'h00, 8'h00, 8'h00, 32'd100);
        send_rows(8'h00, 8'h00, 8'h00, 8'h00, 32'd101);
        send_rows(8'hFE, 8'h00, 8'h00, 8'h00, 32'd200);
        send_rows(8'h0F, 8'h00, 8'h00, 8'h00, 32'd201);

        // 4x3, largest hold: bit 7 ignored, no long press possible
        write_settings({30'd0, PAD_4X3}, 32'hFFFF_FFFF);
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'h3F, 32'd0);
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'h3F, 32'h7FFF_FFFF);

        // unused layout: nothing decodes, the held key is released
        write_settings({30'd0, PAD_UNUSED}, 32'd5);
        send_rows(8'h00, 8'h00, 8'h00, 8'h00, 32'd0);
        send_rows(8'h00, 8'h00, 8'h00, 8'h00, 32'd100);

        for (int p = 0; p < PHASES; p++) begin
            layout_word = $urandom();
            case (p % 3)
                0:       layout_word[1:0] = PAD_4X4;
                1:       layout_word[1:0] = PAD_4X3;
                default: layout_word[1:0] = PAD_1X4;
            endcase
            if (p == 6) layout_word[1:0] = PAD_UNUSED;
            case (p % 5)
                0:       hold = $urandom_range(40, 1);
                1:       hold = 32'd0;
                2:       hold = 32'hFFFF_FFFF;
                3:       hold = $urandom();
                default: hold = $urandom_range(60, 1);
            endcase
            write_settings(layout_word, hold);
            stim_clock = $urandom();
            tx_gap_max = (p % 4 == 1 || p % 4 == 3) ? 0 : GAP_MAX;
            rx_gap_max = (p % 4 == 2 || p % 4 == 3) ? 0 : GAP_MAX;
            if (p == 4) begin
                // sender keeps offering while the sink stalls for a long stretch
                tx_gap_max = 0;
                hold_off_req <= 1'b1;
            end
            run_scan_episodes(PHASE_ITEMS);
        end

        wait_until_events_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_events == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
